FILE: rtl/core/sfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

  localparam int MAX_FRAMES_DEF    = 64;
  localparam int MAX_SHEET_DIM_DEF = 16;

  localparam int CELL_W   = 8;
  localparam int HOLD_W   = 16;
  localparam int Q16_W    = 17;
  localparam int ELAPSE_W = 17;
  localparam int POS_W    = 7;

  localparam logic [Q16_W-1:0]    Q16_ONE     = 17'h10000;
  localparam logic [ELAPSE_W-1:0] ELAPSED_MAX = 17'h1FFFF;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_PAUSE   = 3'd4
  } cmd_t;

  localparam logic [2:0] REG_COLUMNS = 3'd0;
  localparam logic [2:0] REG_ROWS    = 3'd1;
  localparam logic [2:0] REG_LOOP    = 3'd2;
  localparam logic [2:0] REG_COUNT   = 3'd3;
  localparam logic [2:0] REG_CELL_W  = 3'd4;
  localparam logic [2:0] REG_CELL_H  = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/core/sfs_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sfs_div #(
  parameter int DW = 5
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [sfs_pkg::CELL_W-1:0] dividend,
  input  wire logic [DW-1:0]             divisor,
  output logic      [sfs_pkg::CELL_W-1:0] quotient,
  output logic      [DW-1:0]             remainder,
  output logic                           done
);

  localparam int CW = $clog2(sfs_pkg::CELL_W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {remainder, quotient[sfs_pkg::CELL_W-1]};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        remainder <= '0;
        quotient  <= dividend;
      end else if (busy) begin
        remainder <= ge ? DW'(trial - {1'b0, divisor}) : DW'(trial);
        quotient  <= {quotient[sfs_pkg::CELL_W-2:0], ge};
        cnt       <= cnt + 1'b1;
        if (cnt == CW'(sfs_pkg::CELL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sprite_frame_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake             Content
// input     in   in_valid / in_stall   cmd, tick_delta, entry_addr, entry_cell, entry_hold
// result    out  out_valid / out_stall cell coords, edges, position, status flags
// config    in   APB (psel/penable)    sheet size, loop, frame count, cell size
//
// A tick that shows a frame passes through table read, hold check, 8 divider steps for
// cell over columns, then two passes through one shared multiply-saturate unit before
// its result is registered. Other ticks end after the hold check, and other commands
// skip the table read; the input reopens as the result is registered. One item is
// in work at a time; a stalled result holds the sequencer until the result register frees.
// Reset is synchronous; the frame table has no reset and holds nothing until written.
module sprite_frame_sequencer #(
  parameter int MAX_FRAMES    = sfs_pkg::MAX_FRAMES_DEF,
  parameter int MAX_SHEET_DIM = sfs_pkg::MAX_SHEET_DIM_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [15:0] tick_delta,
  input  wire logic [5:0]  entry_addr,
  input  wire logic [7:0]  entry_cell,
  input  wire logic [15:0] entry_hold,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       cell_col,
  output logic [3:0]       cell_row,
  output logic [16:0]      u_left,
  output logic [16:0]      u_right,
  output logic [16:0]      v_bottom,
  output logic [16:0]      v_top,
  output logic             coords_valid,
  output logic [6:0]       frame_position,
  output logic             running,
  output logic             finished,
  output logic             bad_cell
);

  localparam int AW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int DW   = $clog2(MAX_SHEET_DIM + 1);
  localparam int PW   = sfs_pkg::POS_W;
  localparam int QW   = sfs_pkg::Q16_W;
  localparam int EW   = sfs_pkg::ELAPSE_W;
  localparam int ENTW = sfs_pkg::CELL_W + sfs_pkg::HOLD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RD, S_CHK, S_DIV, S_MUL0, S_MUL1, S_END, S_OUT
  } state_t;

  // Configuration registers
  logic [4:0]    sheet_columns;
  logic [4:0]    sheet_rows;
  logic          loop_enable;
  logic [6:0]    frame_count;
  logic [QW-1:0] cell_width_q16;
  logic [QW-1:0] cell_height_q16;
  logic          cfg_we;
  logic [2:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_columns   <= 5'd1;
      sheet_rows      <= 5'd1;
      loop_enable     <= 1'b0;
      frame_count     <= 7'd1;
      cell_width_q16  <= sfs_pkg::Q16_ONE;
      cell_height_q16 <= sfs_pkg::Q16_ONE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sfs_pkg::REG_COLUMNS: sheet_columns   <= pwdata[4:0];
        sfs_pkg::REG_ROWS:    sheet_rows      <= pwdata[4:0];
        sfs_pkg::REG_LOOP:    loop_enable     <= pwdata[0];
        sfs_pkg::REG_COUNT:   frame_count     <= pwdata[6:0];
        sfs_pkg::REG_CELL_W:  cell_width_q16  <= pwdata[QW-1:0];
        sfs_pkg::REG_CELL_H:  cell_height_q16 <= pwdata[QW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sfs_pkg::REG_COLUMNS: prdata = 32'(sheet_columns);
      sfs_pkg::REG_ROWS:    prdata = 32'(sheet_rows);
      sfs_pkg::REG_LOOP:    prdata = 32'(loop_enable);
      sfs_pkg::REG_COUNT:   prdata = 32'(frame_count);
      sfs_pkg::REG_CELL_W:  prdata = 32'(cell_width_q16);
      sfs_pkg::REG_CELL_H:  prdata = 32'(cell_height_q16);
      default:              prdata = '0;
    endcase
  end

  // Effective sheet size and frame count
  logic [DW-1:0] cols;
  logic [DW-1:0] rows;
  logic [PW-1:0] fc;

  always_comb begin
    if (sheet_columns == '0) cols = DW'(1);
    else if (32'(sheet_columns) > MAX_SHEET_DIM) cols = DW'(MAX_SHEET_DIM);
    else cols = DW'(sheet_columns);
    if (sheet_rows == '0) rows = DW'(1);
    else if (32'(sheet_rows) > MAX_SHEET_DIM) rows = DW'(MAX_SHEET_DIM);
    else rows = DW'(sheet_rows);
    fc = (32'(frame_count) > MAX_FRAMES) ? PW'(MAX_FRAMES) : frame_count;
  end

  // Sequencer state
  state_t        state;
  sfs_pkg::cmd_t cmd_r;
  logic [15:0]   delta_r;
  logic [5:0]    addr_r;
  logic [7:0]    cell_r;
  logic [15:0]   hold_r;
  logic [PW-1:0] pos;
  logic [EW-1:0] elapsed;
  logic          active;
  logic          playing;
  logic          stop_pending;
  logic          shown;
  logic          bad;
  logic [DW-1:0] col_r;
  logic [DW-1:0] row_r;
  logic [QW-1:0] ul_r, ur_r, vb_r, vt_r;

  // Frame table
  logic [ENTW-1:0] frame_table [MAX_FRAMES];
  logic [ENTW-1:0] rd_entry;

  always_ff @(posedge clk) begin
    if (state == S_EXEC && cmd_r == sfs_pkg::CMD_WRITE && 32'(addr_r) < MAX_FRAMES) begin
      frame_table[AW'(addr_r)] <= {cell_r, hold_r};
    end
    if (state == S_RD) begin
      rd_entry <= frame_table[AW'(pos)];
    end
  end

  // Show check
  logic          can_show;
  logic          hold_ok;
  logic          at_end;
  logic          div_start;
  logic          div_done;
  logic [7:0]    div_q;
  logic [DW-1:0] div_r;

  assign at_end    = (pos >= fc);
  assign can_show  = active && (pos < fc) && (32'(pos) < MAX_FRAMES);
  assign hold_ok   = (elapsed <= {1'b0, rd_entry[sfs_pkg::HOLD_W-1:0]});
  assign div_start = (state == S_CHK) && can_show && hold_ok;

  sfs_div #(
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_entry[ENTW-1:sfs_pkg::HOLD_W]),
    .divisor  (cols),
    .quotient (div_q),
    .remainder(div_r),
    .done     (div_done)
  );

  // Shared multiply-saturate unit: edge = sat(a * size), far = sat(edge + size)
  logic                ridx_bad;
  logic [DW-1:0]       row_calc;
  logic [DW-1:0]       mul_a;
  logic [QW-1:0]       mul_b;
  logic [DW+QW-1:0]    prod;
  logic [QW-1:0]       edge_lo;
  logic [QW:0]         edge_sum;
  logic [QW-1:0]       edge_hi;
  logic [EW:0]         elapsed_sum;

  assign ridx_bad = (div_q >= 8'(rows));
  assign row_calc = ridx_bad ? '0 : DW'(rows - DW'(1) - DW'(div_q));
  assign mul_a    = (state == S_MUL0) ? div_r : row_r;
  assign mul_b    = (state == S_MUL0) ? cell_width_q16 : cell_height_q16;
  assign prod     = (DW+QW)'(mul_a) * (DW+QW)'(mul_b);
  assign edge_lo  = (prod > (DW+QW)'(sfs_pkg::Q16_ONE)) ? sfs_pkg::Q16_ONE : QW'(prod);
  assign edge_sum = (QW+1)'(edge_lo) + (QW+1)'(mul_b);
  assign edge_hi  = (edge_sum > (QW+1)'(sfs_pkg::Q16_ONE)) ? sfs_pkg::Q16_ONE
                                                          : QW'(edge_sum);
  assign elapsed_sum = (EW+1)'(elapsed) + (EW+1)'(delta_r);

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos          <= '0;
      elapsed      <= '0;
      active       <= 1'b1;
      playing      <= 1'b0;
      stop_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state != S_OUT && out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= sfs_pkg::cmd_t'(cmd);
            delta_r <= tick_delta;
            addr_r  <= entry_addr;
            cell_r  <= entry_cell;
            hold_r  <= entry_hold;
            shown   <= 1'b0;
            bad     <= 1'b0;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= (cmd_r == sfs_pkg::CMD_TICK) ? S_RD : S_END;
          case (cmd_r)
            sfs_pkg::CMD_TICK: begin
              if (active && at_end) begin
                if (loop_enable) begin
                  playing <= 1'b1;
                  pos     <= '0;
                  elapsed <= '0;
                end else begin
                  playing <= 1'b0;
                end
              end
            end
            sfs_pkg::CMD_RESTART: begin
              elapsed      <= '0;
              pos          <= '0;
              active       <= 1'b1;
              playing      <= 1'b1;
              stop_pending <= 1'b0;
            end
            sfs_pkg::CMD_STOP: stop_pending <= 1'b1;
            sfs_pkg::CMD_PAUSE: begin
              if (active) begin
                playing <= 1'b0;
                active  <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (!can_show) begin
            state <= S_END;
          end else if (hold_ok) begin
            state <= S_DIV;
          end else begin
            pos     <= pos + 1'b1;
            elapsed <= '0;
            state   <= S_END;
          end
        end
        S_DIV: begin
          if (div_done) state <= S_MUL0;
        end
        S_MUL0: begin
          col_r <= div_r;
          row_r <= row_calc;
          bad   <= ridx_bad;
          ul_r  <= edge_lo;
          ur_r  <= edge_hi;
          state <= S_MUL1;
        end
        S_MUL1: begin
          vb_r    <= edge_lo;
          vt_r    <= edge_hi;
          shown   <= 1'b1;
          elapsed <= (elapsed_sum > (EW+1)'(sfs_pkg::ELAPSED_MAX)) ? sfs_pkg::ELAPSED_MAX
                                                                  : EW'(elapsed_sum);
          state   <= S_END;
        end
        S_END: begin
          // stop-when-done takes effect once the clip sits at its end
          if (cmd_r == sfs_pkg::CMD_TICK && stop_pending && active && at_end) begin
            elapsed      <= '0;
            pos          <= '0;
            playing      <= 1'b0;
            active       <= 1'b0;
            stop_pending <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            cell_col       <= shown ? 4'(col_r) : '0;
            cell_row       <= shown ? 4'(row_r) : '0;
            u_left         <= shown ? ul_r : '0;
            u_right        <= shown ? ur_r : '0;
            v_bottom       <= shown ? vb_r : '0;
            v_top          <= shown ? vt_r : '0;
            coords_valid   <= shown;
            bad_cell       <= shown && bad;
            frame_position <= pos;
            running        <= playing;
            finished       <= active && at_end;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic [3:0]  col;
  logic [3:0]  row;
  logic [16:0] ul;
  logic [16:0] ur;
  logic [16:0] vb;
  logic [16:0] vt;
  logic        shown;
  logic [6:0]  pos;
  logic        run;
  logic        fin;
  logic        bad;
} frame_result_t;

class frame_scoreboard;
  logic [7:0]  cell_tab[sfs_pkg::MAX_FRAMES_DEF];
  logic [15:0] hold_tab[sfs_pkg::MAX_FRAMES_DEF];
  bit          written[sfs_pkg::MAX_FRAMES_DEF];

  int unsigned pos;
  int unsigned elapsed;
  bit          active;
  bit          playing;
  bit          stop_pend;

  int unsigned cols_reg;
  int unsigned rows_reg;
  bit          loop_reg;
  int unsigned count_reg;
  int unsigned width_reg;
  int unsigned height_reg;

  frame_result_t pending_q[$];
  int errors;
  int n_items;
  int n_checked;
  int n_shown;
  int n_bad;
  int n_wraps;

  function new();
    pos = 0;
    elapsed = 0;
    active = 1'b1;
    playing = 1'b0;
    stop_pend = 1'b0;
    cols_reg = 1;
    rows_reg = 1;
    loop_reg = 1'b0;
    count_reg = 1;
    width_reg = 32'(sfs_pkg::Q16_ONE);
    height_reg = 32'(sfs_pkg::Q16_ONE);
    foreach (written[i]) written[i] = 1'b0;
  endfunction

  task report_mismatch(string msg);
    if (errors < 40) $display("ERROR: %s", msg);
    errors++;
  endtask

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      sfs_pkg::REG_COLUMNS: cols_reg = 32'(val[4:0]);
      sfs_pkg::REG_ROWS:    rows_reg = 32'(val[4:0]);
      sfs_pkg::REG_LOOP:    loop_reg = val[0];
      sfs_pkg::REG_COUNT:   count_reg = 32'(val[6:0]);
      sfs_pkg::REG_CELL_W:  width_reg = 32'(val[16:0]);
      sfs_pkg::REG_CELL_H:  height_reg = 32'(val[16:0]);
      default: ;
    endcase
  endfunction

  function int unsigned eff_count();
    return (count_reg > sfs_pkg::MAX_FRAMES_DEF) ? sfs_pkg::MAX_FRAMES_DEF : count_reg;
  endfunction

  function int unsigned clamp_dim(int unsigned d);
    if (d == 0) return 1;
    if (d > sfs_pkg::MAX_SHEET_DIM_DEF) return sfs_pkg::MAX_SHEET_DIM_DEF;
    return d;
  endfunction

  function longint unsigned sat_q16(longint unsigned v);
    return (v > sfs_pkg::Q16_ONE) ? 64'(sfs_pkg::Q16_ONE) : v;
  endfunction

  // Would a tick now read a table entry that holds nothing yet?
  function bit unwritten_read(output int unsigned addr);
    int unsigned p;
    int unsigned fc;
    fc = eff_count();
    p = pos;
    addr = 0;
    if (!active) return 1'b0;
    if (p >= fc) begin
      if (!loop_reg) return 1'b0;
      p = 0;
    end
    if (p < fc && !written[p]) begin
      addr = p;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void accept_item(logic [2:0] c, logic [15:0] delta, logic [5:0] addr,
                            logic [7:0] cell_in, logic [15:0] hold_in);
    frame_result_t r;
    int unsigned fc;
    int unsigned cols;
    int unsigned rows;
    int unsigned ridx;
    int unsigned col_v;
    int unsigned row_v;
    longint unsigned ul;
    longint unsigned ur;
    longint unsigned vb;
    longint unsigned vt;
    fc = eff_count();
    r = '0;
    n_items++;
    case (c)
      sfs_pkg::CMD_TICK: begin
        if (active) begin
          if (pos >= fc) begin
            if (loop_reg) begin
              playing = 1'b1;
              pos = 0;
              elapsed = 0;
              n_wraps++;
            end else begin
              playing = 1'b0;
            end
          end
          if (pos < fc) begin
            if (elapsed <= hold_tab[pos]) begin
              cols = clamp_dim(cols_reg);
              rows = clamp_dim(rows_reg);
              ridx = cell_tab[pos] / cols;
              col_v = cell_tab[pos] % cols;
              if (ridx >= rows) begin
                r.bad = 1'b1;
                row_v = 0;
              end else begin
                row_v = rows - 1 - ridx;
              end
              ul = sat_q16(longint'(col_v) * width_reg);
              ur = sat_q16(ul + width_reg);
              vb = sat_q16(longint'(row_v) * height_reg);
              vt = sat_q16(vb + height_reg);
              r.col = col_v[3:0];
              r.row = row_v[3:0];
              r.ul = ul[16:0];
              r.ur = ur[16:0];
              r.vb = vb[16:0];
              r.vt = vt[16:0];
              r.shown = 1'b1;
              elapsed = elapsed + delta;
              if (elapsed > sfs_pkg::ELAPSED_MAX) elapsed = 32'(sfs_pkg::ELAPSED_MAX);
              n_shown++;
              if (r.bad) n_bad++;
            end else begin
              pos++;
              elapsed = 0;
            end
          end
        end
        // stop-when-done fires once the clip sits at its end
        if (stop_pend && active && pos >= fc) begin
          elapsed = 0;
          pos = 0;
          playing = 1'b0;
          active = 1'b0;
          stop_pend = 1'b0;
        end
      end
      sfs_pkg::CMD_WRITE: begin
        cell_tab[addr] = cell_in;
        hold_tab[addr] = hold_in;
        written[addr] = 1'b1;
      end
      sfs_pkg::CMD_RESTART: begin
        elapsed = 0;
        pos = 0;
        active = 1'b1;
        playing = 1'b1;
        stop_pend = 1'b0;
      end
      sfs_pkg::CMD_STOP: stop_pend = 1'b1;
      sfs_pkg::CMD_PAUSE: begin
        if (active) begin
          playing = 1'b0;
          active = 1'b0;
        end
      end
      default: ;
    endcase
    r.pos = pos[6:0];
    r.run = playing;
    r.fin = active && (pos >= fc);
    pending_q = {pending_q, r};
  endfunction

  task check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                n_checked, name, got, want));
  endtask

  task check_result(frame_result_t got);
    frame_result_t want;
    if (pending_q.size() == 0) begin
      report_mismatch("result arrived with no item outstanding");
      return;
    end
    want = pending_q.pop_front();
    check_field("cell_col", got.col, want.col);
    check_field("cell_row", got.row, want.row);
    check_field("u_left", got.ul, want.ul);
    check_field("u_right", got.ur, want.ur);
    check_field("v_bottom", got.vb, want.vb);
    check_field("v_top", got.vt, want.vt);
    check_field("coords_valid", got.shown, want.shown);
    check_field("frame_position", got.pos, want.pos);
    check_field("running", got.run, want.run);
    check_field("finished", got.fin, want.fin);
    check_field("bad_cell", got.bad, want.bad);
    n_checked++;
  endtask
endclass

module testbench;

  localparam int CYCLE_LIMIT = 500000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  cmd;
  logic [15:0] tick_delta;
  logic [5:0]  entry_addr;
  logic [7:0]  entry_cell;
  logic [15:0] entry_hold;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  cell_col;
  logic [3:0]  cell_row;
  logic [16:0] u_left;
  logic [16:0] u_right;
  logic [16:0] v_bottom;
  logic [16:0] v_top;
  logic        coords_valid;
  logic [6:0]  frame_position;
  logic        running;
  logic        finished;
  logic        bad_cell;

  frame_scoreboard sb;
  frame_result_t   seen;
  int              send_mode;
  int              recv_mode;
  int              stall_left;
  int              cycle_count;
  int              settings_used;

  sprite_frame_sequencer uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .tick_delta(tick_delta),
    .entry_addr(entry_addr),
    .entry_cell(entry_cell),
    .entry_hold(entry_hold),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cell_col(cell_col),
    .cell_row(cell_row),
    .u_left(u_left),
    .u_right(u_right),
    .v_bottom(v_bottom),
    .v_top(v_top),
    .coords_valid(coords_valid),
    .frame_position(frame_position),
    .running(running),
    .finished(finished),
    .bad_cell(bad_cell)
  );

  always #5 clk = ~clk;

  // mode 0: never idle, 1: uniform 0..18, 2: mostly back to back with bursts
  function automatic int gap_cycles(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sprite_frame_sequencer: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.col = cell_col;
      seen.row = cell_row;
      seen.ul = u_left;
      seen.ur = u_right;
      seen.vb = v_bottom;
      seen.vt = v_top;
      seen.shown = coords_valid;
      seen.pos = frame_position;
      seen.run = running;
      seen.fin = finished;
      seen.bad = bad_cell;
      sb.check_result(seen);
      stall_left = gap_cycles(recv_mode);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    // read back through the same port
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val)
      sb.report_mismatch($sformatf("register %0d reads %0h, written %0h", idx, prdata, val));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic [4:0] cols, logic [4:0] rows, logic lp, logic [6:0] cnt,
                           logic [16:0] w, logic [16:0] h);
    reg_write(sfs_pkg::REG_COLUMNS, 32'(cols));
    reg_write(sfs_pkg::REG_ROWS, 32'(rows));
    reg_write(sfs_pkg::REG_LOOP, 32'(lp));
    reg_write(sfs_pkg::REG_COUNT, 32'(cnt));
    reg_write(sfs_pkg::REG_CELL_W, 32'(w));
    reg_write(sfs_pkg::REG_CELL_H, 32'(h));
    settings_used++;
  endtask

  task automatic send_item(logic [2:0] c, logic [15:0] d, logic [5:0] a, logic [7:0] ce,
                           logic [15:0] h);
    int gap;
    gap = gap_cycles(send_mode);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= c;
    tick_delta <= d;
    entry_addr <= a;
    entry_cell <= ce;
    entry_hold <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.accept_item(c, d, a, ce, h);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_item(int unsigned hold_max, int unsigned delta_max);
    logic [2:0]  c;
    logic [15:0] d;
    logic [15:0] h;
    logic [5:0]  a;
    logic [7:0]  ce;
    int unsigned pick;
    int unsigned fc;
    int unsigned fill_addr;
    d = 16'($urandom);
    h = 16'($urandom);
    a = 6'($urandom);
    ce = 8'($urandom);
    fc = sb.eff_count();
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      c = sfs_pkg::CMD_TICK;
      case ($urandom_range(0, 9))
        0: ;
        1: d = '0;
        default: d = 16'($urandom_range(0, delta_max));
      endcase
    end else if (pick < 80) begin
      c = sfs_pkg::CMD_WRITE;
      if ($urandom_range(0, 3) != 0) a = 6'($urandom_range(0, (fc > 0) ? fc - 1 : 0));
      if ($urandom_range(0, 9) != 0) h = 16'($urandom_range(0, hold_max));
    end else if (pick < 86) begin
      c = sfs_pkg::CMD_RESTART;
    end else if (pick < 91) begin
      c = sfs_pkg::CMD_STOP;
    end else if (pick < 94) begin
      c = sfs_pkg::CMD_PAUSE;
    end else begin
      c = 3'($urandom_range(5, 7));
    end
    // fill an empty table slot before a tick could read it
    if (c == sfs_pkg::CMD_TICK && sb.unwritten_read(fill_addr)) begin
      c = sfs_pkg::CMD_WRITE;
      a = 6'(fill_addr);
      h = 16'($urandom_range(0, hold_max));
    end
    send_item(c, d, a, ce, h);
  endtask

  task automatic run_phase(logic [4:0] cols, logic [4:0] rows, logic lp, logic [6:0] cnt,
                           logic [16:0] w, logic [16:0] h, int n_items, bit hold_off,
                           int smode, int rmode);
    int unsigned hold_max;
    int unsigned delta_max;
    drain_results();
    configure(cols, rows, lp, cnt, w, h);
    send_mode = smode;
    recv_mode = rmode;
    case ($urandom_range(0, 3))
      0: hold_max = 4;
      1: hold_max = 40;
      2: hold_max = 1000;
      default: hold_max = 65535;
    endcase
    case ($urandom_range(0, 3))
      0: delta_max = 2;
      1: delta_max = 20;
      2: delta_max = 500;
      default: delta_max = 65535;
    endcase
    send_item(sfs_pkg::CMD_RESTART, 16'($urandom), 6'($urandom), 8'($urandom),
              16'($urandom));
    for (int i = 0; i < n_items; i++) begin
      random_item(hold_max, delta_max);
      if (hold_off && i == n_items / 2) drain_results();
    end
  endtask

  task automatic directed_items();
    // reset settings: one cell sheet, one frame, no loop
    send_item(sfs_pkg::CMD_WRITE, 16'h0, 6'd0, 8'd0, 16'd3);
    send_item(sfs_pkg::CMD_TICK, 16'd0, 6'd0, 8'd0, 16'd0);
    send_item(sfs_pkg::CMD_TICK, 16'hFFFF, 6'd0, 8'd0, 16'd0);
    send_item(sfs_pkg::CMD_TICK, 16'd0, 6'd0, 8'd0, 16'd0);      // elapsed past hold: advance
    send_item(sfs_pkg::CMD_TICK, 16'd0, 6'd0, 8'd0, 16'd0);      // at end, no loop
    send_item(sfs_pkg::CMD_STOP, 16'd0, 6'd0, 8'd0, 16'd0);
    send_item(sfs_pkg::CMD_TICK, 16'd0, 6'd0, 8'd0, 16'd0);      // pending stop rewinds
    send_item(sfs_pkg::CMD_TICK, 16'hFFFF, 6'h3F, 8'hFF, 16'hFFFF);
    send_item(sfs_pkg::CMD_PAUSE, 16'd0, 6'd0, 8'd0, 16'd0);     // no clip active
    send_item(sfs_pkg::CMD_RESTART, 16'd0, 6'd0, 8'd0, 16'd0);
    send_item(3'd5, 16'hFFFF, 6'h3F, 8'hFF, 16'hFFFF);
    send_item(3'd7, 16'hFFFF, 6'h3F, 8'hFF, 16'hFFFF);
    send_item(sfs_pkg::CMD_WRITE, 16'd0, 6'd63, 8'hFF, 16'hFFFF);
    send_item(sfs_pkg::CMD_WRITE, 16'd0, 6'd0, 8'd1, 16'd0);     // cell below the sheet
    send_item(sfs_pkg::CMD_TICK, 16'hFFFF, 6'd0, 8'd0, 16'd0);
    send_item(sfs_pkg::CMD_PAUSE, 16'd0, 6'd0, 8'd0, 16'd0);
    send_item(sfs_pkg::CMD_RESTART, 16'd0, 6'd0, 8'd0, 16'd0);
    drain_results();
    configure(5'd16, 5'd4, 1'b1, 7'd2, 17'd4096, 17'd16384);
    send_item(sfs_pkg::CMD_WRITE, 16'd0, 6'd0, 8'd255, 16'd0);
    send_item(sfs_pkg::CMD_WRITE, 16'd0, 6'd1, 8'd17, 16'd0);
    send_item(sfs_pkg::CMD_RESTART, 16'd0, 6'd0, 8'd0, 16'd0);
    for (int i = 0; i < 5; i++) send_item(sfs_pkg::CMD_TICK, 16'd100, 6'd0, 8'd0, 16'd0);
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    cmd = sfs_pkg::CMD_TICK;
    tick_delta = '0;
    entry_addr = '0;
    entry_cell = '0;
    entry_hold = '0;
    out_stall = 1'b0;
    stall_left = 0;
    cycle_count = 0;
    settings_used = 0;
    send_mode = 1;
    recv_mode = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_items();

    // corner settings first, then random sheets
    run_phase(5'd0, 5'd31, 1'b0, 7'd0, 17'd0, 17'h1FFFF, 150, 1'b1, 1, 1);
    run_phase(5'd31, 5'd0, 1'b1, 7'd127, 17'h1FFFF, 17'd1, 150, 1'b0, 2, 1);
    run_phase(5'd16, 5'd16, 1'b1, 7'd64, 17'd4096, 17'd4096, 150, 1'b0, 1, 2);
    run_phase(5'd1, 5'd1, 1'b0, 7'd1, 17'd65536, 17'd65536, 150, 1'b1, 0, 0);
    for (int p = 0; p < 8; p++) begin
      logic [4:0]  cols;
      logic [4:0]  rows;
      logic [6:0]  cnt;
      logic [16:0] w;
      logic [16:0] h;
      if ($urandom_range(0, 5) == 0) begin
        cols = 5'($urandom);
        rows = 5'($urandom);
        w = 17'($urandom);
        h = 17'($urandom);
      end else begin
        cols = 5'($urandom_range(1, 16));
        rows = 5'($urandom_range(1, 16));
        w = 17'd65536 / cols;
        h = 17'd65536 / rows;
      end
      cnt = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(1, 12));
      run_phase(cols, rows, 1'($urandom_range(0, 1)), cnt, w, h, 150, (p % 3) == 0,
                $urandom_range(0, 2), $urandom_range(0, 2));
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d items under %0d register settings", sb.n_items, settings_used);
    $display("%0d frames shown, %0d off the sheet, %0d loop wraps",
             sb.n_shown, sb.n_bad, sb.n_wraps);
    if (sb.errors == 0) begin
      $display("sprite_frame_sequencer: match");
    end else begin
      $display("%0d errors", sb.errors);
      $display("sprite_frame_sequencer: mismatch");
    end
    $finish;
  end

endmodule
